@@ src/tfn_pkg.sv @@
// shared constants, types and helpers for the triangle face normal core
// no dependencies; every other file refers to this package by scoped names
`timescale 1ns / 1ps
package tfn_pkg;

  // coordinate width of one vertex component (signed q15.8 at 24 bits)
  localparam int unsigned CoordWidth = 24;
  localparam int unsigned DiffWidth  = CoordWidth + 1;
  localparam int unsigned ProdWidth  = 2 * DiffWidth;
  localparam int unsigned CrossWidth = ProdWidth + 1;
  localparam int unsigned ShiftWidth = $clog2(CrossWidth + 1);

  localparam int unsigned RootWidth  = 16;
  localparam int unsigned SqWidth    = 2 * RootWidth;
  localparam int unsigned SumWidth   = SqWidth + 2;
  localparam int unsigned QWidth     = 15;
  localparam int unsigned QMax       = 16384;
  localparam int unsigned FracShift  = 30;
  localparam int unsigned AccWidth   = 2 * QWidth + SumWidth + 2;
  localparam int unsigned OutWidth   = 16;

  typedef logic [CrossWidth-1:0] cross_mag_t;
  typedef logic [ShiftWidth-1:0] shift_t;

  // sideband that travels alongside one transaction
  typedef struct packed {
    logic       valid;
    logic       degen;
    logic [2:0] neg;
  } side_t;

  // number of significant bits of an unsigned word
  function automatic shift_t bit_len(cross_mag_t v);
    shift_t n;
    n = '0;
    for (int i = 0; i < CrossWidth; i++) begin
      if (v[i]) begin
        n = shift_t'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

@@ src/tfn_cross.sv @@
// edge vectors and cross product, three register stages
// depends on tfn_pkg
`timescale 1ns / 1ps
module tfn_cross (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      valid_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0]     a_x_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0]     a_y_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0]     a_z_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0]     b_x_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0]     b_y_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0]     b_z_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0]     c_x_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0]     c_y_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0]     c_z_i,
  output logic                                      valid_o,
  output logic [2:0][tfn_pkg::CrossWidth-1:0]       mag_o,
  output logic [2:0]                                neg_o
);

  localparam int unsigned CW = tfn_pkg::CoordWidth;
  localparam int unsigned DW = tfn_pkg::DiffWidth;
  localparam int unsigned PW = tfn_pkg::ProdWidth;
  localparam int unsigned NW = tfn_pkg::CrossWidth;

  logic [2:0] valid_q;

  logic signed [DW-1:0] v1_d [3];
  logic signed [DW-1:0] v2_d [3];
  logic signed [DW-1:0] v1_q [3];
  logic signed [DW-1:0] v2_q [3];
  logic signed [PW-1:0] p_d [6];
  logic signed [PW-1:0] p_q [6];
  logic signed [NW-1:0] n_d [3];
  logic [2:0][NW-1:0]   mag_d;
  logic [2:0][NW-1:0]   mag_q;
  logic [2:0]           neg_d;
  logic [2:0]           neg_q;

  always_comb begin
    v1_d[0] = $signed({a_x_i[CW-1], a_x_i}) - $signed({b_x_i[CW-1], b_x_i});
    v1_d[1] = $signed({a_y_i[CW-1], a_y_i}) - $signed({b_y_i[CW-1], b_y_i});
    v1_d[2] = $signed({a_z_i[CW-1], a_z_i}) - $signed({b_z_i[CW-1], b_z_i});
    v2_d[0] = $signed({a_x_i[CW-1], a_x_i}) - $signed({c_x_i[CW-1], c_x_i});
    v2_d[1] = $signed({a_y_i[CW-1], a_y_i}) - $signed({c_y_i[CW-1], c_y_i});
    v2_d[2] = $signed({a_z_i[CW-1], a_z_i}) - $signed({c_z_i[CW-1], c_z_i});
  end

  always_comb begin
    p_d[0] = v1_q[1] * v2_q[2];
    p_d[1] = v1_q[2] * v2_q[1];
    p_d[2] = v1_q[2] * v2_q[0];
    p_d[3] = v1_q[0] * v2_q[2];
    p_d[4] = v1_q[0] * v2_q[1];
    p_d[5] = v1_q[1] * v2_q[0];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_d[i] = $signed({p_q[2*i][PW-1], p_q[2*i]}) - $signed({p_q[2*i+1][PW-1], p_q[2*i+1]});
      neg_d[i] = n_d[i][NW-1];
      mag_d[i] = neg_d[i] ? NW'(-n_d[i]) : NW'(n_d[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      v1_q[i] <= v1_d[i];
      v2_q[i] <= v2_d[i];
    end
    for (int i = 0; i < 6; i++) begin
      p_q[i] <= p_d[i];
    end
    mag_q <= mag_d;
    neg_q <= neg_d;
  end

  assign valid_o = valid_q[2];
  assign mag_o   = mag_q;
  assign neg_o   = neg_q;

endmodule

@@ src/tfn_norm.sv @@
// block normalisation of the cross product, squares and their sum
// four register stages; depends on tfn_pkg
`timescale 1ns / 1ps
module tfn_norm (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  logic [2:0][tfn_pkg::CrossWidth-1:0]   mag_i,
  input  logic [2:0]                            neg_i,
  output tfn_pkg::side_t                        side_o,
  output logic [2:0][tfn_pkg::SqWidth-1:0]      sq_o,
  output logic [tfn_pkg::SumWidth-1:0]          sum_o
);

  localparam int unsigned NW = tfn_pkg::CrossWidth;
  localparam int unsigned RW = tfn_pkg::RootWidth;
  localparam int unsigned SQ = tfn_pkg::SqWidth;
  localparam int unsigned SW = tfn_pkg::SumWidth;

  logic [3:0] valid_q;
  tfn_pkg::side_t side4_q, side5_q, side6_q, side7_q;

  tfn_pkg::shift_t  bl_d;
  tfn_pkg::shift_t  k_d;
  tfn_pkg::shift_t  k_q;
  logic [2:0][NW-1:0] mag_q;
  logic [2:0][NW-1:0] shifted_d;
  logic [2:0][RW-1:0] r_q;
  logic [2:0][SQ-1:0] sq_q;
  logic [2:0][SQ-1:0] sq7_q;
  logic [SW-1:0]      sum_q;

  always_comb begin
    bl_d = tfn_pkg::bit_len(mag_i[0] | mag_i[1] | mag_i[2]);
    k_d  = (bl_d > tfn_pkg::shift_t'(RW)) ? bl_d - tfn_pkg::shift_t'(RW) : '0;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shifted_d[i] = mag_q[i] >> k_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    k_q           <= k_d;
    mag_q         <= mag_i;
    side4_q.valid <= valid_i;
    side4_q.degen <= (bl_d == '0);
    side4_q.neg   <= neg_i;
    for (int i = 0; i < 3; i++) begin
      r_q[i]  <= shifted_d[i][RW-1:0];
      sq_q[i] <= SQ'(r_q[i]) * SQ'(r_q[i]);
    end
    side5_q <= side4_q;
    side6_q <= side5_q;
    side7_q <= side6_q;
    sq7_q   <= sq_q;
    sum_q   <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
  end

  always_comb begin
    side_o       = side7_q;
    side_o.valid = valid_q[3];
  end

  assign sq_o  = sq7_q;
  assign sum_o = sum_q;

endmodule

@@ src/tfn_unit_scale.sv @@
// bit-per-stage search for the unit scale of one component
// largest q <= 16384 with (2q-1)^2 * s <= r^2 * 2^30; depends on tfn_pkg
`timescale 1ns / 1ps
module tfn_unit_scale (
  input  logic                          clk_i,
  input  logic [tfn_pkg::SqWidth-1:0]   r_sq_i,
  input  logic [tfn_pkg::SumWidth-1:0]  sum_i,
  output logic [tfn_pkg::QWidth-1:0]    q_o
);

  localparam int unsigned QW = tfn_pkg::QWidth;
  localparam int unsigned AW = tfn_pkg::AccWidth;

  // q, q*s and q^2*s travel down the stages so no multiplier is needed
  logic [QW-1:0] q_q   [1:QW];
  logic [AW-1:0] q1_q  [1:QW];
  logic [AW-1:0] q2_q  [1:QW];
  logic [AW-1:0] s_q   [1:QW];
  logic [AW-1:0] rhs_q [1:QW];

  for (genvar g = 0; g < QW; g++) begin : g_step
    localparam int unsigned J = QW - 1 - g;

    logic [QW-1:0] q_in;
    logic [AW-1:0] q1_in;
    logic [AW-1:0] q2_in;
    logic [AW-1:0] s_in;
    logic [AW-1:0] rhs_in;
    logic [QW-1:0] cand;
    logic [AW-1:0] c1;
    logic [AW-1:0] c2;
    logic [AW-1:0] lhs;
    logic          ok;

    if (g == 0) begin : g_first
      assign q_in   = '0;
      assign q1_in  = '0;
      assign q2_in  = '0;
      assign s_in   = AW'(sum_i);
      assign rhs_in = AW'(r_sq_i) << tfn_pkg::FracShift;
    end else begin : g_next
      assign q_in   = q_q[g];
      assign q1_in  = q1_q[g];
      assign q2_in  = q2_q[g];
      assign s_in   = s_q[g];
      assign rhs_in = rhs_q[g];
    end

    always_comb begin
      cand = q_in | (QW'(1) << J);
      c1   = q1_in + (s_in << J);
      c2   = q2_in + (q1_in << (J + 1)) + (s_in << (2 * J));
      lhs  = (c2 << 2) - (c1 << 2) + s_in;
      ok   = (cand <= QW'(tfn_pkg::QMax)) && (lhs <= rhs_in);
    end

    always_ff @(posedge clk_i) begin
      q_q[g+1]   <= ok ? cand : q_in;
      q1_q[g+1]  <= ok ? c1 : q1_in;
      q2_q[g+1]  <= ok ? c2 : q2_in;
      s_q[g+1]   <= s_in;
      rhs_q[g+1] <= rhs_in;
    end
  end

  assign q_o = q_q[QW];

endmodule

@@ src/triangle_face_normal_core.sv @@
// Unit face normal of one triangle: a transaction is taken on every cycle that start is
// high (busy stays low, the pipeline never stalls), and its result appears with done_o
// at the end of the pipeline, one result per cycle at full rate: 3 stages of edge vectors
// and cross product, 4 of normalisation and squares, 15 of the bit-per-stage scale search
// and one output register. Results cannot be held off, so they must be taken when shown.
// Depends on tfn_pkg, tfn_cross, tfn_norm and tfn_unit_scale.
`timescale 1ns / 1ps
module triangle_face_normal_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [tfn_pkg::CoordWidth-1:0]  vertex_a_x_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0]  vertex_a_y_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0]  vertex_a_z_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0]  vertex_b_x_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0]  vertex_b_y_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0]  vertex_b_z_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0]  vertex_c_x_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0]  vertex_c_y_i,
  input  logic signed [tfn_pkg::CoordWidth-1:0]  vertex_c_z_i,
  output logic                                   done_o,
  output logic signed [tfn_pkg::OutWidth-1:0]    normal_x_o,
  output logic signed [tfn_pkg::OutWidth-1:0]    normal_y_o,
  output logic signed [tfn_pkg::OutWidth-1:0]    normal_z_o,
  output logic                                   degenerate_o
);

  localparam int unsigned QW = tfn_pkg::QWidth;
  localparam int unsigned OW = tfn_pkg::OutWidth;
  localparam logic signed [OW-1:0] QLim = OW'(tfn_pkg::QMax);

  logic                                  cross_valid;
  logic [2:0][tfn_pkg::CrossWidth-1:0]   cross_mag;
  logic [2:0]                            cross_neg;
  tfn_pkg::side_t                        norm_side;
  logic [2:0][tfn_pkg::SqWidth-1:0]      norm_sq;
  logic [tfn_pkg::SumWidth-1:0]          norm_sum;
  logic [QW-1:0]                         q [3];

  logic [QW-1:0]   vld_q;
  tfn_pkg::side_t  info_q [QW];
  tfn_pkg::side_t  info_out;
  logic [QW-1:0]   q_clamp [3];
  logic [OW-1:0]   res_d [3];

  logic            done_q;
  logic            degen_q;
  logic [OW-1:0]   res_q [3];

  assign busy = 1'b0;

  tfn_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .a_x_i   (vertex_a_x_i),
    .a_y_i   (vertex_a_y_i),
    .a_z_i   (vertex_a_z_i),
    .b_x_i   (vertex_b_x_i),
    .b_y_i   (vertex_b_y_i),
    .b_z_i   (vertex_b_z_i),
    .c_x_i   (vertex_c_x_i),
    .c_y_i   (vertex_c_y_i),
    .c_z_i   (vertex_c_z_i),
    .valid_o (cross_valid),
    .mag_o   (cross_mag),
    .neg_o   (cross_neg)
  );

  tfn_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cross_valid),
    .mag_i   (cross_mag),
    .neg_i   (cross_neg),
    .side_o  (norm_side),
    .sq_o    (norm_sq),
    .sum_o   (norm_sum)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    tfn_unit_scale u_scale (
      .clk_i  (clk_i),
      .r_sq_i (norm_sq[i]),
      .sum_i  (norm_sum),
      .q_o    (q[i])
    );
  end

  // sideband delay line matching the scale search
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QW-2:0], norm_side.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    info_q[0] <= norm_side;
    for (int i = 1; i < QW; i++) begin
      info_q[i] <= info_q[i-1];
    end
  end

  assign info_out = info_q[QW-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_clamp[i] = (q[i] > QW'(tfn_pkg::QMax)) ? QW'(tfn_pkg::QMax) : q[i];
      if (info_out.degen) begin
        res_d[i] = '0;
      end else if (info_out.neg[i]) begin
        res_d[i] = -OW'(q_clamp[i]);
      end else begin
        res_d[i] = OW'(q_clamp[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    degen_q <= info_out.degen;
    for (int i = 0; i < 3; i++) begin
      res_q[i] <= res_d[i];
    end
  end

  assign done_o       = done_q;
  assign degenerate_o = done_q & degen_q;
  assign normal_x_o   = res_q[0];
  assign normal_y_o   = res_q[1];
  assign normal_z_o   = res_q[2];

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    degenerate_o |-> (normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0))
    else $error("degenerate transaction with a non-zero normal");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (normal_x_o <= QLim && normal_x_o >= -QLim &&
                normal_y_o <= QLim && normal_y_o >= -QLim &&
                normal_z_o <= QLim && normal_z_o >= -QLim))
    else $error("normal component beyond unit range");

  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !degenerate_o) |->
      (normal_x_o != '0 || normal_y_o != '0 || normal_z_o != '0))
    else $error("non-degenerate transaction gave a zero normal");

endmodule

@@ bench/tb_top.sv @@
// self-checking bench for triangle_face_normal_core: random and directed triangles,
// each normal predicted in the bench and checked against the core's output; needs tfn_pkg
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned CycleLimit = 200000;

  typedef logic signed [tfn_pkg::CoordWidth-1:0] coord_t;

  typedef struct {
    coord_t      v[9];      // a.xyz, b.xyz, c.xyz
    int unsigned gap;       // idle cycles after this transaction
    bit          drain;     // hold off until every pending normal has come back
  } tri_t;

  typedef struct {
    logic signed [tfn_pkg::OutWidth-1:0] nx, ny, nz;
    logic                                degen;
  } normal_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  coord_t vert[9] = '{default: '0};
  logic   done_o;
  logic signed [tfn_pkg::OutWidth-1:0] normal_x_o, normal_y_o, normal_z_o;
  logic   degenerate_o;

  tri_t    tri_queue[$];
  normal_t normal_queue[$];
  int unsigned n_sent = 0, n_checked = 0, n_degen = 0, n_cycles = 0, gap_left = 0;
  bit      failed = 1'b0;

  triangle_face_normal_core uut (
    .clk_i, .rst_ni, .start, .busy,
    .vertex_a_x_i(vert[0]), .vertex_a_y_i(vert[1]), .vertex_a_z_i(vert[2]),
    .vertex_b_x_i(vert[3]), .vertex_b_y_i(vert[4]), .vertex_b_z_i(vert[5]),
    .vertex_c_x_i(vert[6]), .vertex_c_y_i(vert[7]), .vertex_c_z_i(vert[8]),
    .done_o, .normal_x_o, .normal_y_o, .normal_z_o, .degenerate_o
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // exact cross product, block normalised to 16 bits, then the largest q with
  // (2q-1)^2 * s <= 2^30 * r^2, i.e. round-half-away of 16384 * r / sqrt(s)
  function automatic normal_t face_normal(tri_t t);
    logic signed [67:0] p[9], e1[3], e2[3], cr[3];
    logic [67:0] mag[3];
    logic [63:0] r[3], s, lo, hi, mid, tq, rhs, q[3];
    bit          neg[3];
    int          maxbl, shift;
    normal_t     res;
    maxbl = 0;
    for (int i = 0; i < 9; i++) p[i] = t.v[i];
    for (int i = 0; i < 3; i++) begin
      e1[i] = p[i] - p[3+i];
      e2[i] = p[i] - p[6+i];
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    for (int i = 0; i < 3; i++) begin
      neg[i] = cr[i] < 0;
      mag[i] = neg[i] ? -cr[i] : cr[i];
      for (int b = 0; b < 68; b++) if (mag[i][b] && b + 1 > maxbl) maxbl = b + 1;
    end
    if (maxbl == 0) begin
      res.nx = '0; res.ny = '0; res.nz = '0; res.degen = 1'b1;
      return res;
    end
    shift = (maxbl > 16) ? maxbl - 16 : 0;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      r[i] = 64'(16'(mag[i] >> shift));
      s += r[i] * r[i];
    end
    for (int i = 0; i < 3; i++) begin
      lo = 0; hi = tfn_pkg::QMax;
      rhs = (r[i] * r[i]) << tfn_pkg::FracShift;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        tq = 2 * mid - 1;
        if (tq * tq * s <= rhs) lo = mid; else hi = mid - 1;
      end
      q[i] = (lo > tfn_pkg::QMax) ? 64'(tfn_pkg::QMax) : lo;
      if (neg[i]) q[i] = -q[i];
    end
    res.nx = q[0][15:0]; res.ny = q[1][15:0]; res.nz = q[2][15:0]; res.degen = 1'b0;
    return res;
  endfunction

  function automatic coord_t rand_coord(int unsigned span);
    case (span)
      0: rand_coord = coord_t'($urandom);
      1: rand_coord = coord_t'($urandom_range(0, 511)) - 256;
      default: rand_coord = coord_t'($urandom_range(0, 131071)) - 65536;
    endcase
  endfunction

  task automatic add_tri(input coord_t a[3], input coord_t b[3], input coord_t c[3],
                         input int unsigned gap, input bit drain);
    tri_t t;
    for (int i = 0; i < 3; i++) begin
      t.v[i] = a[i]; t.v[3+i] = b[i]; t.v[6+i] = c[i];
    end
    t.gap = gap;
    t.drain = drain;
    tri_queue.push_back(t);
  endtask

  initial begin
    coord_t a[3], b[3], c[3];
    coord_t mx, mn;
    int unsigned span, gmode;
    mx = {1'b0, {(tfn_pkg::CoordWidth-1){1'b1}}};
    mn = {1'b1, {(tfn_pkg::CoordWidth-1){1'b0}}};
    // degenerate: all zero, repeated vertex, collinear points
    add_tri('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, 0, 0);
    add_tri('{100, 5, -7}, '{100, 5, -7}, '{3, 9, 11}, 0, 0);
    add_tri('{0, 0, 0}, '{256, 512, 768}, '{-256, -512, -768}, 1, 0);
    // axis aligned, both orientations, exact unit components
    add_tri('{0, 0, 0}, '{256, 0, 0}, '{0, 256, 0}, 0, 0);
    add_tri('{0, 0, 0}, '{0, 256, 0}, '{256, 0, 0}, 0, 0);
    add_tri('{0, 0, 0}, '{0, 256, 0}, '{0, 0, 256}, 2, 0);
    add_tri('{0, 0, 0}, '{0, 0, 256}, '{0, 256, 0}, 0, 0);
    add_tri('{0, 0, 0}, '{0, 0, 256}, '{256, 0, 0}, 0, 0);
    add_tri('{0, 0, 0}, '{256, 0, 0}, '{0, 0, 256}, 0, 0);
    // diagonal and tiny triangles
    add_tri('{0, 0, 0}, '{1, 0, 0}, '{0, 1, 1}, 0, 0);
    add_tri('{1, 1, 1}, '{0, 0, 0}, '{1, 0, -1}, 3, 0);
    // extreme coordinates: largest edge vectors and cross products
    add_tri('{mx, mx, mx}, '{mn, mn, mx}, '{mn, mx, mn}, 0, 0);
    add_tri('{mn, mn, mn}, '{mx, mx, mn}, '{mx, mn, mx}, 0, 0);
    add_tri('{mx, mn, mx}, '{mn, mx, mn}, '{mx, mx, mn}, 0, 1);
    add_tri('{mx, mx, mx}, '{mn, mn, mn}, '{mx, mn, mn}, 0, 0);
    add_tri('{mx, mx, mx}, '{mx, mx, mx}, '{mn, mn, mn}, 6, 0);
    add_tri('{mn, 0, 0}, '{mx, 0, 0}, '{mn, mx, 0}, 0, 0);
    add_tri('{mx, 1, -1}, '{mn, -1, 1}, '{0, mn, mx}, 0, 0);
    // random part: stretches of back-to-back and of gapped traffic
    for (int n = 0; n < 440; n++) begin
      if (n % 40 == 0) gmode = $urandom_range(0, 2);
      span = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) begin
        a[i] = rand_coord(span); b[i] = rand_coord(span); c[i] = rand_coord(span);
      end
      case ($urandom_range(0, 19))
        0: b = a;
        1: c = b;
        2: for (int i = 0; i < 3; i++) c[i] = a[i] + (a[i] - b[i]) * 2;
        default: ;
      endcase
      add_tri(a, b, c, (gmode == 0) ? 0 : (gmode == 1) ? $urandom_range(0, 6)
              : $urandom_range(0, 1), n == 200 || n == 350);
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver: presents one transaction at a time from the pending list
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        tri_t t;
        for (int i = 0; i < 9; i++) t.v[i] = vert[i];
        normal_queue.push_back(face_normal(t));
        n_sent++;
      end
      if (start && busy) begin
        // hold the current transaction
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (tri_queue.size() > 0 &&
                   !(tri_queue[0].drain && normal_queue.size() > 0)) begin
        tri_t t;
        t = tri_queue.pop_front();
        for (int i = 0; i < 9; i++) vert[i] <= t.v[i];
        gap_left <= t.gap;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every done_o strobe is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (normal_queue.size() == 0) begin
        $error("unexpected result: nx=%0d ny=%0d nz=%0d", normal_x_o, normal_y_o, normal_z_o);
        failed = 1'b1;
      end else begin
        normal_t e;
        e = normal_queue.pop_front();
        if (normal_x_o !== e.nx) begin
          $error("normal_x: expected %0d, got %0d", e.nx, normal_x_o); failed = 1'b1;
        end
        if (normal_y_o !== e.ny) begin
          $error("normal_y: expected %0d, got %0d", e.ny, normal_y_o); failed = 1'b1;
        end
        if (normal_z_o !== e.nz) begin
          $error("normal_z: expected %0d, got %0d", e.nz, normal_z_o); failed = 1'b1;
        end
        if (degenerate_o !== e.degen) begin
          $error("degenerate: expected %0b, got %0b", e.degen, degenerate_o); failed = 1'b1;
        end
        if (e.degen) n_degen++;
        n_checked++;
      end
    end
  end

  initial begin
    @(posedge rst_ni);
    while (tri_queue.size() > 0 || gap_left > 0 || start || normal_queue.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (40) @(posedge clk_i);
    $display("%0d triangles sent, %0d normals checked, %0d of them degenerate",
             n_sent, n_checked, n_degen);
    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CycleLimit) begin
      $display("timeout with %0d transactions outstanding", normal_queue.size());
      $display("Verification failed");
      $finish;
    end
  end

endmodule

@@ files.f @@
src/tfn_pkg.sv
src/tfn_cross.sv
src/tfn_norm.sv
src/tfn_unit_scale.sv
src/triangle_face_normal_core.sv
bench/tb_top.sv
